// ===== design/nba_pkg.sv =====
// ----------------------------------------------------------------------------
// nba_pkg
// Types and constants shared by the basemul-accumulate block.
// ----------------------------------------------------------------------------
package nba_pkg;

   localparam logic [11:0]        MOD_Q          = 12'd3329;
   localparam logic [15:0]        QINV_NEG       = 16'd62209;
   localparam logic signed [31:0] BARRETT_V      = 32'sd20159;
   localparam logic signed [31:0] BARRETT_ROUND  = 32'sd33554432;
   localparam logic signed [15:0] MONT_R2        = 16'sd1353;

   localparam int                 CSR_AW         = 3;
   localparam logic               CSR_IDX_TO_MONT = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_M11,
      ST_MZ,
      ST_M00,
      ST_M01,
      ST_M10,
      ST_BAR_E,
      ST_BAR_O,
      ST_TM_E,
      ST_TM_O,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      MX_A_EVEN,
      MX_A_ODD,
      MX_TMP,
      MX_RES_E,
      MX_RES_O
   } mx_sel_type;

   typedef enum logic [1:0] {
      MY_B_EVEN,
      MY_B_ODD,
      MY_TWIDDLE,
      MY_R2
   } my_sel_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_TMP,
      DST_ACC_E,
      DST_ACC_O,
      DST_RES_E,
      DST_RES_O
   } dest_type;

   typedef struct packed {
      logic signed [15:0] a_even;
      logic signed [15:0] a_odd;
      logic signed [15:0] b_even;
      logic signed [15:0] b_odd;
      logic signed [12:0] twiddle;
      logic               first_term;
      logic               last_term;
   } item_type;

   typedef struct packed {
      logic       load_in;
      logic       mont_start;
      mx_sel_type mont_x;
      my_sel_type mont_y;
      dest_type   mont_dest;
      logic       bar_start;
      logic       bar_odd;
      dest_type   bar_dest;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic mont_busy;
      logic mont_done;
      logic bar_busy;
      logic bar_done;
      logic last_term;
      logic out_free;
   } status_type;

endpackage

// ===== design/nba_req_if.sv =====
// ----------------------------------------------------------------------------
// nba_req_if
// Input item channel: coefficient pairs, twiddle and term flags.
// ----------------------------------------------------------------------------
interface nba_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] a_even;
   logic signed [15:0] a_odd;
   logic signed [15:0] b_even;
   logic signed [15:0] b_odd;
   logic signed [12:0] twiddle;
   logic               first_term;
   logic               last_term;

   modport source (
      output valid, a_even, a_odd, b_even, b_odd, twiddle, first_term, last_term,
      input  ready
   );
   modport sink (
      input  valid, a_even, a_odd, b_even, b_odd, twiddle, first_term, last_term,
      output ready
   );
endinterface

// ===== design/nba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nba_rsp_if
// Result item channel: reduced coefficient pair.
// ----------------------------------------------------------------------------
interface nba_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] c_even;
   logic signed [15:0] c_odd;

   modport source (
      output valid, c_even, c_odd,
      input  ready
   );
   modport sink (
      input  valid, c_even, c_odd,
      output ready
   );
endinterface

// ===== design/nba_ctrl.sv =====
// ----------------------------------------------------------------------------
// nba_ctrl
// Sequencer: issues the Montgomery and Barrett operations of one term.
// ----------------------------------------------------------------------------
module nba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 to_mont,
   input  nba_pkg::status_type  status,
   output logic                 req_ready,
   output nba_pkg::cmd_type     cmd
);

   nba_pkg::state_type state_ff;
   nba_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nba_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = nba_pkg::ST_M11;
            end
         end
         nba_pkg::ST_M11: begin
            if (status.mont_done) begin
               state_in = nba_pkg::ST_MZ;
            end
         end
         nba_pkg::ST_MZ: begin
            if (status.mont_done) begin
               state_in = nba_pkg::ST_M00;
            end
         end
         nba_pkg::ST_M00: begin
            if (status.mont_done) begin
               state_in = nba_pkg::ST_M01;
            end
         end
         nba_pkg::ST_M01: begin
            if (status.mont_done) begin
               state_in = nba_pkg::ST_M10;
            end
         end
         nba_pkg::ST_M10: begin
            if (status.mont_done) begin
               state_in = status.last_term ? nba_pkg::ST_BAR_E : nba_pkg::ST_IDLE;
            end
         end
         nba_pkg::ST_BAR_E: begin
            if (status.bar_done) begin
               state_in = nba_pkg::ST_BAR_O;
            end
         end
         nba_pkg::ST_BAR_O: begin
            if (status.bar_done) begin
               state_in = to_mont ? nba_pkg::ST_TM_E : nba_pkg::ST_EMIT;
            end
         end
         nba_pkg::ST_TM_E: begin
            if (status.mont_done) begin
               state_in = nba_pkg::ST_TM_O;
            end
         end
         nba_pkg::ST_TM_O: begin
            if (status.mont_done) begin
               state_in = nba_pkg::ST_EMIT;
            end
         end
         nba_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = nba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nba_pkg::ST_IDLE;
         end
      endcase
   end

   logic mont_go;
   logic bar_go;

   assign mont_go = !status.mont_busy && !status.mont_done;
   assign bar_go  = !status.bar_busy && !status.bar_done;

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mont_x    = nba_pkg::MX_A_EVEN;
      cmd.mont_y    = nba_pkg::MY_B_EVEN;
      cmd.mont_dest = nba_pkg::DST_NONE;
      cmd.bar_dest  = nba_pkg::DST_NONE;
      case (state_ff)
         nba_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         nba_pkg::ST_M11: begin
            cmd.mont_x     = nba_pkg::MX_A_ODD;
            cmd.mont_y     = nba_pkg::MY_B_ODD;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_TMP;
            end
         end
         nba_pkg::ST_MZ: begin
            cmd.mont_x     = nba_pkg::MX_TMP;
            cmd.mont_y     = nba_pkg::MY_TWIDDLE;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_ACC_E;
            end
         end
         nba_pkg::ST_M00: begin
            cmd.mont_x     = nba_pkg::MX_A_EVEN;
            cmd.mont_y     = nba_pkg::MY_B_EVEN;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_ACC_E;
            end
         end
         nba_pkg::ST_M01: begin
            cmd.mont_x     = nba_pkg::MX_A_EVEN;
            cmd.mont_y     = nba_pkg::MY_B_ODD;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_ACC_O;
            end
         end
         nba_pkg::ST_M10: begin
            cmd.mont_x     = nba_pkg::MX_A_ODD;
            cmd.mont_y     = nba_pkg::MY_B_EVEN;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_ACC_O;
            end
         end
         nba_pkg::ST_BAR_E: begin
            cmd.bar_odd   = 1'b0;
            cmd.bar_start = bar_go;
            if (status.bar_done) begin
               cmd.bar_dest = nba_pkg::DST_RES_E;
            end
         end
         nba_pkg::ST_BAR_O: begin
            cmd.bar_odd   = 1'b1;
            cmd.bar_start = bar_go;
            if (status.bar_done) begin
               cmd.bar_dest = nba_pkg::DST_RES_O;
            end
         end
         nba_pkg::ST_TM_E: begin
            cmd.mont_x     = nba_pkg::MX_RES_E;
            cmd.mont_y     = nba_pkg::MY_R2;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_RES_E;
            end
         end
         nba_pkg::ST_TM_O: begin
            cmd.mont_x     = nba_pkg::MX_RES_O;
            cmd.mont_y     = nba_pkg::MY_R2;
            cmd.mont_start = mont_go;
            if (status.mont_done) begin
               cmd.mont_dest = nba_pkg::DST_RES_O;
            end
         end
         nba_pkg::ST_EMIT: begin
            cmd.load_out = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/nba_datapath.sv =====
// ----------------------------------------------------------------------------
// nba_datapath
// Operand registers, Montgomery and Barrett pipelines, sums, output register.
// ----------------------------------------------------------------------------
module nba_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  nba_pkg::item_type    item,
   input  nba_pkg::cmd_type     cmd,
   output nba_pkg::status_type  status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_c_even,
   output logic signed [15:0]   rsp_c_odd
);

   logic signed [15:0] a0_ff, a1_ff, b0_ff, b1_ff;
   logic signed [12:0] zeta_ff;
   logic               last_ff;
   logic signed [15:0] tmp_ff;
   logic signed [15:0] acc_e_ff, acc_o_ff;
   logic signed [15:0] res_e_ff, res_o_ff;

   // operand capture
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         a0_ff   <= item.a_even;
         a1_ff   <= item.a_odd;
         b0_ff   <= item.b_even;
         b1_ff   <= item.b_odd;
         zeta_ff <= item.twiddle;
         last_ff <= item.last_term;
      end
   end

   // Montgomery pipeline: product, low-half quotient, reduce
   logic signed [15:0] mx, my;
   logic signed [31:0] mp_in, mp_ff, mp2_ff;
   logic        [15:0] mt_in, mt_ff;
   logic signed [32:0] md;
   logic signed [15:0] mr_ff;
   logic               mv1_ff, mv2_ff, mv3_ff;

   always_comb begin
      case (cmd.mont_x)
         nba_pkg::MX_A_EVEN: mx = a0_ff;
         nba_pkg::MX_A_ODD:  mx = a1_ff;
         nba_pkg::MX_TMP:    mx = tmp_ff;
         nba_pkg::MX_RES_E:  mx = res_e_ff;
         nba_pkg::MX_RES_O:  mx = res_o_ff;
         default:            mx = a0_ff;
      endcase
      case (cmd.mont_y)
         nba_pkg::MY_B_EVEN:  my = b0_ff;
         nba_pkg::MY_B_ODD:   my = b1_ff;
         nba_pkg::MY_TWIDDLE: my = 16'(zeta_ff);
         nba_pkg::MY_R2:      my = nba_pkg::MONT_R2;
         default:             my = b0_ff;
      endcase
   end

   assign mp_in = 32'(mx) * 32'(my);
   assign mt_in = 16'(32'(mp_ff[15:0]) * 32'(nba_pkg::QINV_NEG));
   assign md    = 33'(mp2_ff) - 33'(signed'(mt_ff)) * 33'(nba_pkg::MOD_Q);

   always_ff @(posedge clock) begin
      mp_ff  <= mp_in;
      mt_ff  <= mt_in;
      mp2_ff <= mp_ff;
      mr_ff  <= md[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv1_ff <= 1'b0;
         mv2_ff <= 1'b0;
         mv3_ff <= 1'b0;
      end else begin
         mv1_ff <= cmd.mont_start;
         mv2_ff <= mv1_ff;
         mv3_ff <= mv2_ff;
      end
   end

   // Barrett pipeline: quotient estimate, then subtract
   logic signed [15:0] bx, bx_ff;
   logic signed [31:0] bp;
   logic signed [5:0]  bt_ff;
   logic signed [17:0] bd;
   logic signed [15:0] br_ff;
   logic               bv1_ff, bv2_ff;

   assign bx = cmd.bar_odd ? acc_o_ff : acc_e_ff;
   assign bp = 32'(bx) * nba_pkg::BARRETT_V + nba_pkg::BARRETT_ROUND;
   assign bd = 18'(bx_ff) - 18'(bt_ff) * 18'(nba_pkg::MOD_Q);

   always_ff @(posedge clock) begin
      bx_ff <= bx;
      bt_ff <= bp[31:26];
      br_ff <= bd[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv1_ff <= 1'b0;
         bv2_ff <= 1'b0;
      end else begin
         bv1_ff <= cmd.bar_start;
         bv2_ff <= bv1_ff;
      end
   end

   // result write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_e_ff <= '0;
         acc_o_ff <= '0;
      end else if (cmd.load_in && item.first_term) begin
         acc_e_ff <= '0;
         acc_o_ff <= '0;
      end else if (cmd.mont_dest == nba_pkg::DST_ACC_E) begin
         acc_e_ff <= acc_e_ff + mr_ff;
      end else if (cmd.mont_dest == nba_pkg::DST_ACC_O) begin
         acc_o_ff <= acc_o_ff + mr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mont_dest == nba_pkg::DST_TMP) begin
         tmp_ff <= mr_ff;
      end
      if (cmd.mont_dest == nba_pkg::DST_RES_E) begin
         res_e_ff <= mr_ff;
      end else if (cmd.bar_dest == nba_pkg::DST_RES_E) begin
         res_e_ff <= br_ff;
      end
      if (cmd.mont_dest == nba_pkg::DST_RES_O) begin
         res_o_ff <= mr_ff;
      end else if (cmd.bar_dest == nba_pkg::DST_RES_O) begin
         res_o_ff <= br_ff;
      end
   end

   // output register
   logic               out_valid_ff;
   logic signed [15:0] out_e_ff, out_o_ff;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_e_ff <= res_e_ff;
         out_o_ff <= res_o_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_c_even = out_e_ff;
   assign rsp_c_odd  = out_o_ff;

   assign status.mont_busy = mv1_ff || mv2_ff;
   assign status.mont_done = mv3_ff;
   assign status.bar_busy  = bv1_ff;
   assign status.bar_done  = bv2_ff;
   assign status.last_term = last_ff;
   assign status.out_free  = out_free;

   a_one_op_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mv1_ff, mv2_ff, mv3_ff, bv1_ff, bv2_ff}))
      else $error("more than one operation in flight");

   a_writeback_on_done: assert property (@(posedge clock) disable iff (reset)
      ((cmd.mont_dest != nba_pkg::DST_NONE) |-> mv3_ff) and
      ((cmd.bar_dest != nba_pkg::DST_NONE) |-> bv2_ff))
      else $error("write-back without a finished operation");

   a_load_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("output register overwritten while held");

endmodule

// ===== design/ntt_basemul_accumulate_top.sv =====
// ----------------------------------------------------------------------------
// ntt_basemul_accumulate_top
// NTT-domain pair multiply-accumulate with Montgomery and Barrett reduction.
//
// req_ch brings one term per item: a coefficient pair of each vector, the
// pair's twiddle and the first_term / last_term flags. first_term clears the
// even and odd sums before the term is added; last_term reduces the sums and
// sends one item on rsp_ch. The sums are kept after a result is sent.
// One item is worked on at a time through a single Montgomery pipeline (five
// multiplies per term): req_ch.ready rises again once the last multiply of
// a term without last_term is done. For a final term a Barrett pass on each
// sum follows, then, if to_montgomery is set, a Montgomery multiply of each
// result by MONT_R2, and then the output load. The result sits in an output
// register, so a stalled rsp_ch holds the next term only when that term is
// final and reaches its output load. Register 0 (to_montgomery, APB address
// 0) must be written by the user only while idle; the block does not check it.
// Reset clears the sums, the register, the sequencer and rsp_ch.valid.
// ----------------------------------------------------------------------------
module ntt_basemul_accumulate_top (
   input  logic                         clock,
   input  logic                         reset,
   nba_req_if.sink                      req_ch,
   nba_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [nba_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   logic                to_mont_ff;
   logic                csr_hit;
   nba_pkg::cmd_type    cmd;
   nba_pkg::status_type status;
   nba_pkg::item_type   item;
   logic                req_ready;

   assign csr_hit = (paddr[nba_pkg::CSR_AW-1:2] == nba_pkg::CSR_IDX_TO_MONT);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? {31'd0, to_mont_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         to_mont_ff <= 1'b0;
      end else if (psel && penable && pwrite && csr_hit) begin
         to_mont_ff <= pwdata[0];
      end
   end

   assign item.a_even     = req_ch.a_even;
   assign item.a_odd      = req_ch.a_odd;
   assign item.b_even     = req_ch.b_even;
   assign item.b_odd      = req_ch.b_odd;
   assign item.twiddle    = req_ch.twiddle;
   assign item.first_term = req_ch.first_term;
   assign item.last_term  = req_ch.last_term;
   assign req_ch.ready    = req_ready;

   nba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .to_mont   (to_mont_ff),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   nba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .cmd        (cmd),
      .status     (status),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_c_even (rsp_ch.c_even),
      .rsp_c_odd  (rsp_ch.c_odd)
   );

endmodule
